[src/nmqs_pkg.sv]
// Shared types and constants for the NCO quarter-sine mixer.
// Used by the front, queue, back and top-level modules; no dependencies.
package nmqs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 17;
  localparam int PHASE_W    = 32;
  localparam int MAG_W      = 15;
  localparam int IDX_MAX_W  = 16;  // table index field, wide enough for the largest table
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP  = 1'b0,
    REG_START_PHASE = 1'b1
  } cfg_reg_t;

  // One classified sample waiting for the arithmetic side
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] xi;
    logic signed [SAMPLE_W-1:0] xq;
    logic                       last;
    logic                       neg_sin;
    logic                       neg_cos;
    logic [IDX_MAX_W-1:0]       sin_idx;
    logic [IDX_MAX_W-1:0]       cos_idx;
    logic [PHASE_W-1:0]         phase;
  } nmqs_item_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } nmqs_q_stat_t;

endpackage

[src/nmqs_front.sv]
// Front end: phase accumulator, config registers and table index/sign classification.
// Depends on nmqs_pkg.
module nmqs_front #(
  parameter int SINE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nmqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nmqs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  logic signed [nmqs_pkg::SAMPLE_W-1:0] in_i,
  input  logic signed [nmqs_pkg::SAMPLE_W-1:0] in_q,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                push,
  output nmqs_pkg::nmqs_item_t                push_item
);
  import nmqs_pkg::*;

  localparam int IDX_W = (SINE_DEPTH > 1) ? $clog2(SINE_DEPTH) : 1;
  localparam int SZ_W  = IDX_MAX_W + 1;
  localparam int FRAC_W = PHASE_W - 2;
  localparam int MUL_W = FRAC_W + SZ_W;
  localparam logic [SZ_W-1:0]  TSZ     = SZ_W'(SINE_DEPTH);
  localparam logic [SZ_W-1:0]  TOP_IDX = SZ_W'(SINE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(SINE_DEPTH - 1);

  logic [PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_W-1:0] phase_step_r, phase_step_nxt;
  logic [1:0]         quad;
  logic [MUL_W-1:0]   scaled;
  logic [SZ_W-1:0]    sidx_full;
  logic [IDX_W-1:0]   sidx, cidx;
  logic [PHASE_W-1:0] phase_adv;

  assign push = in_valid && !q_full;

  // Quadrant and scaled table index from the current phase
  assign quad      = phase_acc_r[PHASE_W-1 -: 2];
  assign scaled    = MUL_W'(phase_acc_r[FRAC_W-1:0]) * MUL_W'(TSZ);
  assign sidx_full = scaled[MUL_W-1 -: SZ_W];
  assign sidx      = (sidx_full > TOP_IDX) ? IDX_TOP : sidx_full[IDX_W-1:0];
  assign cidx      = IDX_TOP - sidx;
  assign phase_adv = phase_acc_r + phase_step_r;

  // Item for the queue: indices swap in odd quadrants
  always_comb begin
    push_item.xi      = in_i;
    push_item.xq      = in_q;
    push_item.last    = in_last;
    push_item.neg_sin = quad[1];
    push_item.neg_cos = quad[1] ^ quad[0];
    push_item.sin_idx = IDX_MAX_W'(quad[0] ? cidx : sidx);
    push_item.cos_idx = IDX_MAX_W'(quad[0] ? sidx : cidx);
    push_item.phase   = phase_adv;
  end

  // Register writes and phase advance
  always_comb begin
    phase_acc_nxt  = phase_acc_r;
    phase_step_nxt = phase_step_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:  phase_step_nxt = cfg_wdata;
        REG_START_PHASE: phase_acc_nxt  = cfg_wdata;
        default: ;
      endcase
    end else if (push) begin
      phase_acc_nxt = phase_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= '0;
    end else begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
    end
  end

endmodule

[src/nmqs_queue.sv]
// Short FIFO of classified items between the front and back ends.
// Depends on nmqs_pkg.
module nmqs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  nmqs_pkg::nmqs_item_t   push_item,
  input  logic                   pop,
  output nmqs_pkg::nmqs_item_t   head,
  output nmqs_pkg::nmqs_q_stat_t stat
);
  import nmqs_pkg::*;

  nmqs_item_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/nmqs_back.sv]
// Back end: quarter-sine ROM lookup, complex multiply and output register.
// Depends on nmqs_pkg; ROM contents are built at elaboration.
module nmqs_back #(
  parameter int SINE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nmqs_pkg::nmqs_item_t               head,
  input  nmqs_pkg::nmqs_q_stat_t             q_stat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [nmqs_pkg::OUT_W-1:0]  out_i,
  output logic signed [nmqs_pkg::OUT_W-1:0]  out_q,
  output logic [nmqs_pkg::PHASE_W-1:0]       out_phase,
  output logic                               out_last
);
  import nmqs_pkg::*;

  localparam int IDX_W = (SINE_DEPTH > 1) ? $clog2(SINE_DEPTH) : 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  typedef logic [MAG_W-1:0] rom_t [SINE_DEPTH];

  // sin over a quarter turn, polynomial in Q30, rounded to Q0.15
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x, x2, t, s, v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = (64'(i) * HALF_PI_Q30) / 64'(SINE_DEPTH);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      r[i] = (v > 64'd32767) ? MAG_W'(32767) : v[MAG_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage 1: ROM read
  logic                       v1_r, v1_nxt, en1;
  logic [MAG_W-1:0]           sin_mag_r, cos_mag_r;
  logic signed [SAMPLE_W-1:0] xi1_r, xq1_r;
  logic                       last1_r, neg_sin1_r, neg_cos1_r;
  logic [PHASE_W-1:0]         phase1_r;

  // Stage 2: products
  logic                       v2_r, v2_nxt, en2;
  logic signed [SAMPLE_W-1:0] sv, cv;
  logic signed [PROD_W-1:0]   p_ci_r, p_sq_r, p_si_r, p_cq_r;
  logic                       last2_r;
  logic [PHASE_W-1:0]         phase2_r;

  // Stage 3: sums and output register
  logic                       out_valid_r, out_valid_nxt, en3;
  logic signed [PROD_W:0]     sum_i, sum_q;
  logic signed [OUT_W-1:0]    out_i_r, out_q_r;
  logic [PHASE_W-1:0]         out_phase_r;
  logic                       out_last_r;

  // Stall chain back from the output
  assign en3 = !out_valid_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign pop = en1 && !q_stat.empty;

  always_comb begin
    v1_nxt        = en1 ? !q_stat.empty : v1_r;
    v2_nxt        = en2 ? v1_r : v2_r;
    out_valid_nxt = en3 ? v2_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ROM read, registered data
  always_ff @(posedge clk) begin
    if (en1) begin
      sin_mag_r  <= SINE_ROM[head.sin_idx[IDX_W-1:0]];
      cos_mag_r  <= SINE_ROM[head.cos_idx[IDX_W-1:0]];
      xi1_r      <= head.xi;
      xq1_r      <= head.xq;
      last1_r    <= head.last;
      neg_sin1_r <= head.neg_sin;
      neg_cos1_r <= head.neg_cos;
      phase1_r   <= head.phase;
    end
  end

  // Signed table values
  always_comb begin
    sv = signed'({1'b0, sin_mag_r});
    cv = signed'({1'b0, cos_mag_r});
    if (neg_sin1_r) begin
      sv = -sv;
    end
    if (neg_cos1_r) begin
      cv = -cv;
    end
  end

  // Four products
  always_ff @(posedge clk) begin
    if (en2) begin
      p_ci_r   <= PROD_W'(cv) * PROD_W'(xi1_r);
      p_sq_r   <= PROD_W'(sv) * PROD_W'(xq1_r);
      p_si_r   <= PROD_W'(sv) * PROD_W'(xi1_r);
      p_cq_r   <= PROD_W'(cv) * PROD_W'(xq1_r);
      last2_r  <= last1_r;
      phase2_r <= phase1_r;
    end
  end

  // Sum and floor shift by 15
  assign sum_i = (PROD_W+1)'(p_ci_r) - (PROD_W+1)'(p_sq_r);
  assign sum_q = (PROD_W+1)'(p_si_r) + (PROD_W+1)'(p_cq_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      out_i_r     <= sum_i[PROD_W-1 -: OUT_W];
      out_q_r     <= sum_q[PROD_W-1 -: OUT_W];
      out_phase_r <= phase2_r;
      out_last_r  <= last2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;
  assign out_phase = out_phase_r;
  assign out_last  = out_last_r;

endmodule

[src/nco_mixer_quarter_sine_table_unit.sv]
// Top level of the NCO complex mixer with a quarter-wave sine table.
// Instantiates nmqs_front, nmqs_queue and nmqs_back; depends on nmqs_pkg.
//
//   port group | handshake              | payload
//   -----------+------------------------+------------------------------------
//   in_        | in_valid / in_stall    | in_i, in_q, in_last
//   out_       | out_valid / out_stall  | out_i, out_q, out_phase, out_last
//   cfg_       | cfg_we                 | cfg_index, cfg_wdata
//
// One item per clock sustained while out_stall is low; an accepted item passes
// through the queue, ROM read stage, multiply stage and output register.
// The ROM is a constant table with two registered read ports, so there is no
// fill after reset; synchronous reset clears the phase, step and all valids.
// in_stall rises only when the four-entry queue is full; out_stall holds the
// back pipeline stage by stage while the front keeps filling the queue.
module nco_mixer_quarter_sine_table_unit #(
  parameter int SINE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nmqs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nmqs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [nmqs_pkg::SAMPLE_W-1:0] in_i,
  input  logic signed [nmqs_pkg::SAMPLE_W-1:0] in_q,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nmqs_pkg::OUT_W-1:0]    out_i,
  output logic signed [nmqs_pkg::OUT_W-1:0]    out_q,
  output logic [nmqs_pkg::PHASE_W-1:0]         out_phase,
  output logic                                 out_last
);
  import nmqs_pkg::*;

  logic         push, pop;
  nmqs_item_t   push_item, head;
  nmqs_q_stat_t q_stat;

  assign in_stall = q_stat.full;

  nmqs_front #(
    .SINE_DEPTH(SINE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_i      (in_i),
    .in_q      (in_q),
    .in_last   (in_last),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  nmqs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  nmqs_back #(
    .SINE_DEPTH(SINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q),
    .out_phase (out_phase),
    .out_last  (out_last)
  );

  // Queue flags never both set
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Back end only takes from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
